### rtl/mmlp_pkg.sv
// shared types, constants and the note frequency table of the mml play parser
// no dependencies; imported by every rtl file of the block
package mmlp_pkg;

    localparam int MAX_DOTS    = 15;
    localparam int W_FREQ      = 12;
    localparam int W_DUR       = 14;
    localparam int W_NUM       = 34;
    localparam int W_DEN       = 29;
    localparam int C_WHOLE_MS  = 240000;
    localparam int C_TONES     = 84;
    localparam int C_MAX_LEN   = 64;
    localparam int C_MIN_TEMPO = 32;
    localparam int C_MAX_TEMPO = 255;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_string;
    } t_in_beat;

    typedef struct packed {
        logic [W_FREQ-1:0] freq_hz;
        logic [W_DUR-1:0]  dur_ms;
        logic              last_of_run;
    } t_out_beat;

    // divider request: whole-note numerator and tempo * length denominator
    typedef struct packed {
        logic       start;
        logic [7:0] tempo;
        logic [6:0] len;
        logic [3:0] dots;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [W_DUR-1:0] q;
    } t_div_rsp;

    function automatic logic [W_FREQ-1:0] tone_hz(input logic [6:0] idx);
        logic [W_FREQ-1:0] f;
        case (idx)
            7'd0:  f = 12'd16;   7'd1:  f = 12'd17;   7'd2:  f = 12'd18;
            7'd3:  f = 12'd19;   7'd4:  f = 12'd21;   7'd5:  f = 12'd22;
            7'd6:  f = 12'd23;   7'd7:  f = 12'd25;   7'd8:  f = 12'd26;
            7'd9:  f = 12'd28;   7'd10: f = 12'd29;   7'd11: f = 12'd31;
            7'd12: f = 12'd33;   7'd13: f = 12'd35;   7'd14: f = 12'd37;
            7'd15: f = 12'd39;   7'd16: f = 12'd41;   7'd17: f = 12'd44;
            7'd18: f = 12'd46;   7'd19: f = 12'd49;   7'd20: f = 12'd52;
            7'd21: f = 12'd55;   7'd22: f = 12'd58;   7'd23: f = 12'd62;
            7'd24: f = 12'd65;   7'd25: f = 12'd69;   7'd26: f = 12'd73;
            7'd27: f = 12'd78;   7'd28: f = 12'd82;   7'd29: f = 12'd87;
            7'd30: f = 12'd93;   7'd31: f = 12'd98;   7'd32: f = 12'd104;
            7'd33: f = 12'd110;  7'd34: f = 12'd117;  7'd35: f = 12'd123;
            7'd36: f = 12'd131;  7'd37: f = 12'd139;  7'd38: f = 12'd147;
            7'd39: f = 12'd156;  7'd40: f = 12'd165;  7'd41: f = 12'd175;
            7'd42: f = 12'd185;  7'd43: f = 12'd196;  7'd44: f = 12'd208;
            7'd45: f = 12'd220;  7'd46: f = 12'd233;  7'd47: f = 12'd247;
            7'd48: f = 12'd262;  7'd49: f = 12'd277;  7'd50: f = 12'd294;
            7'd51: f = 12'd311;  7'd52: f = 12'd330;  7'd53: f = 12'd349;
            7'd54: f = 12'd370;  7'd55: f = 12'd392;  7'd56: f = 12'd415;
            7'd57: f = 12'd440;  7'd58: f = 12'd466;  7'd59: f = 12'd494;
            7'd60: f = 12'd523;  7'd61: f = 12'd554;  7'd62: f = 12'd587;
            7'd63: f = 12'd622;  7'd64: f = 12'd659;  7'd65: f = 12'd698;
            7'd66: f = 12'd740;  7'd67: f = 12'd784;  7'd68: f = 12'd831;
            7'd69: f = 12'd880;  7'd70: f = 12'd932;  7'd71: f = 12'd988;
            7'd72: f = 12'd1047; 7'd73: f = 12'd1109; 7'd74: f = 12'd1175;
            7'd75: f = 12'd1245; 7'd76: f = 12'd1319; 7'd77: f = 12'd1397;
            7'd78: f = 12'd1480; 7'd79: f = 12'd1568; 7'd80: f = 12'd1661;
            7'd81: f = 12'd1760; 7'd82: f = 12'd1865; 7'd83: f = 12'd1976;
            7'd84: f = 12'd2093;
            default: f = 12'd0;
        endcase
        return f;
    endfunction

endpackage

### rtl/mmlp_div.sv
// shared restoring divider: full duration = whole-note ms * dot factor / (tempo * len)
// one quotient bit per cycle; depends on mmlp_pkg
module mmlp_div import mmlp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [3:0]             r_cnt, n_cnt;
    logic [W_NUM-1:0]       r_rem, n_rem;
    logic [W_DEN+W_DUR-2:0] r_dsh, n_dsh;
    logic [W_DUR-1:0]       r_q, n_q;
    logic [W_NUM:0]         num;
    logic [W_DEN-1:0]       den;
    logic [14:0]            prod;

    always_comb begin
        // numerator 240000 * (2^(k+1) - 1), denominator tempo * len * 2^k
        num  = ((W_NUM+1)'(C_WHOLE_MS) << ({1'b0, i_req.dots} + 5'd1))
               - (W_NUM+1)'(C_WHOLE_MS);
        prod = 15'(i_req.tempo) * 15'(i_req.len);
        den  = W_DEN'(prod) << i_req.dots;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 4'(W_DUR - 1);
            n_rem  = num[W_NUM-1:0];
            n_dsh  = {den, {(W_DUR-1){1'b0}}};
            n_q    = '0;
        end else if (r_busy) begin
            if ({{(W_DEN+W_DUR-1-W_NUM){1'b0}}, r_rem} >= r_dsh) begin
                n_rem = r_rem - r_dsh[W_NUM-1:0];
                n_q   = {r_q[W_DUR-2:0], 1'b1};
            end else begin
                n_q   = {r_q[W_DUR-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

### rtl/mml_play_parser.sv
// mml play parser: one character per input beat, 0 to 4 tone beats out per character.
// a character is handed to the pending command, or closes it and begins a new one; end of
// string also closes the command left pending and restores the reset state. each note or rest
// runs through the shared 14-step divider before its tone beats are pushed. a character is taken
// only when the previous one is done; a tone beat waits while both hold and output registers are full.
// sync active-low reset: octave 4, length 4, tempo 120, normal. depends on mmlp_pkg, mmlp_div
module mml_play_parser import mmlp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_FIN   = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_E1    = 4'd4;
    localparam logic [3:0] ST_PUSH  = 4'd5;
    localparam logic [3:0] ST_FDONE = 4'd6;
    localparam logic [3:0] ST_BEGIN = 4'd7;
    localparam logic [3:0] ST_EOS   = 4'd8;
    localparam logic [3:0] ST_RESET = 4'd9;
    localparam logic [3:0] ST_END   = 4'd10;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_OCT      = 4'd1;
    localparam logic [3:0] PH_LEN      = 4'd2;
    localparam logic [3:0] PH_TEMPO    = 4'd3;
    localparam logic [3:0] PH_VOL      = 4'd4;
    localparam logic [3:0] PH_MODE     = 4'd5;
    localparam logic [3:0] PH_NUM      = 4'd6;
    localparam logic [3:0] PH_REST     = 4'd7;
    localparam logic [3:0] PH_NOTE_ACC = 4'd8;
    localparam logic [3:0] PH_NOTE_DIG = 4'd9;
    localparam logic [3:0] PH_NOTE_DOT = 4'd10;

    localparam logic [1:0] K_SIL  = 2'd0;
    localparam logic [1:0] K_NOTE = 2'd1;
    localparam logic [1:0] K_RDOT = 2'd2;

    localparam logic [1:0] AR_NORMAL   = 2'd0;
    localparam logic [1:0] AR_LEGATO   = 2'd1;
    localparam logic [1:0] AR_STACCATO = 2'd2;

    logic [3:0]  r_state, n_state;
    logic [3:0]  r_ret, n_ret;
    logic [2:0]  r_oct, n_oct;
    logic [6:0]  r_deflen, n_deflen;
    logic [7:0]  r_tempo, n_tempo;
    logic [1:0]  r_artic, n_artic;
    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_digit, n_digit;
    logic        r_seen, n_seen;
    logic [4:0]  r_semi, n_semi;
    logic [3:0]  r_dot, n_dot;
    logic [7:0]  r_ch, n_ch;
    logic        r_eos, n_eos;
    logic [1:0]  r_kind, n_kind;
    logic [W_FREQ-1:0] r_freq, n_freq;
    logic [W_DUR-1:0]  r_sil, n_sil;
    logic        r_more, n_more;
    t_out_beat   r_em, n_em;
    t_out_beat   r_hold, n_hold;
    logic        r_hold_v, n_hold_v;
    t_out_beat   r_out, n_out;
    logic        r_out_v, n_out_v;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic [7:0]  uc;
    logic        dig;
    logic [19:0] dig_acc;
    logic [15:0] dig_next;
    logic [6:0]  arg_len;
    logic [6:0]  idx;
    logic        taken;
    logic        rdot;
    logic        clr;
    logic [W_DUR-1:0] full;
    logic [W_DUR-1:0] snd;
    logic [16:0] f7;
    logic [15:0] f3;

    mmlp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        uc  = (r_ch >= "a" && r_ch <= "z") ? r_ch - 8'd32 : r_ch;
        dig = (r_ch >= "0" && r_ch <= "9");
        dig_acc  = {4'b0, r_digit} * 20'd10 + {16'b0, r_ch[3:0]};
        dig_next = (dig_acc > 20'd65535) ? 16'hFFFF : dig_acc[15:0];
        if (!r_seen) begin
            arg_len = r_deflen;
        end else if (r_digit < 16'd1) begin
            arg_len = 7'd1;
        end else if (r_digit > 16'(C_MAX_LEN)) begin
            arg_len = 7'(C_MAX_LEN);
        end else begin
            arg_len = r_digit[6:0];
        end
        idx  = 7'(r_oct) * 7'd12 + 7'(r_semi);
        full = div_rsp.q;
        f7   = 17'(full) * 17'd7;
        f3   = 16'(full) * 16'd3;
        case (r_artic)
            AR_NORMAL:   snd = f7[16:3];
            AR_STACCATO: snd = f3[15:2];
            default:     snd = full;
        endcase

        n_state  = r_state;
        n_ret    = r_ret;
        n_oct    = r_oct;
        n_deflen = r_deflen;
        n_tempo  = r_tempo;
        n_artic  = r_artic;
        n_phase  = r_phase;
        n_digit  = r_digit;
        n_seen   = r_seen;
        n_semi   = r_semi;
        n_dot    = r_dot;
        n_ch     = r_ch;
        n_eos    = r_eos;
        n_kind   = r_kind;
        n_freq   = r_freq;
        n_sil    = r_sil;
        n_more   = r_more;
        n_em     = r_em;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_out    = r_out;
        n_out_v  = r_out_v;
        taken    = 1'b0;
        rdot     = 1'b0;
        clr      = 1'b0;
        div_req.start = 1'b0;
        div_req.tempo = r_tempo;
        div_req.len   = arg_len;
        div_req.dots  = 4'd0;

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_ch    = i_in_data.ch;
                    n_eos   = i_in_data.end_of_string;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                // try to hand the character to the pending command
                case (r_phase)
                    PH_OCT: begin
                        if (r_ch >= "0" && r_ch <= "6") begin
                            n_oct = r_ch[2:0];
                            clr   = 1'b1;
                            taken = 1'b1;
                        end
                    end
                    PH_LEN, PH_TEMPO, PH_VOL, PH_NUM: begin
                        if (dig) begin
                            n_digit = dig_next;
                            n_seen  = 1'b1;
                            taken   = 1'b1;
                        end
                    end
                    PH_MODE: begin
                        taken = 1'b1;
                        clr   = 1'b1;
                        if (uc == "N") begin
                            n_artic = AR_NORMAL;
                        end else if (uc == "L") begin
                            n_artic = AR_LEGATO;
                        end else if (uc == "S") begin
                            n_artic = AR_STACCATO;
                        end else if (uc != "B" && uc != "F") begin
                            taken = 1'b0;
                            clr   = 1'b0;
                        end
                    end
                    PH_REST: begin
                        if (dig) begin
                            n_digit = dig_next;
                            n_seen  = 1'b1;
                            taken   = 1'b1;
                        end else if (r_ch == ".") begin
                            // dotted rest completes at once
                            taken = 1'b1;
                            rdot  = 1'b1;
                            div_req.start = 1'b1;
                            n_kind = K_RDOT;
                            n_ret  = ST_EOS;
                        end
                    end
                    PH_NOTE_ACC, PH_NOTE_DIG: begin
                        if (r_phase == PH_NOTE_ACC && (r_ch == "#" || r_ch == "+")) begin
                            n_semi  = r_semi + 5'd1;
                            n_phase = PH_NOTE_DIG;
                            taken   = 1'b1;
                        end else if (r_phase == PH_NOTE_ACC && r_ch == "-") begin
                            n_semi  = r_semi - 5'd1;
                            n_phase = PH_NOTE_DIG;
                            taken   = 1'b1;
                        end else if (dig) begin
                            n_digit = dig_next;
                            n_seen  = 1'b1;
                            n_phase = PH_NOTE_DIG;
                            taken   = 1'b1;
                        end else if (r_ch == ".") begin
                            n_dot   = 4'd1;
                            n_phase = PH_NOTE_DOT;
                            taken   = 1'b1;
                        end
                    end
                    PH_NOTE_DOT: begin
                        if (r_ch == ".") begin
                            if (r_dot < 4'(MAX_DOTS)) begin
                                n_dot = r_dot + 4'd1;
                            end
                            taken = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (!taken) begin
                    n_ret   = ST_BEGIN;
                    n_state = ST_FIN;
                end else if (rdot) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_EOS;
                end
            end
            ST_FIN: begin
                n_state = ST_FDONE;
                case (r_phase)
                    PH_LEN: begin
                        if (r_digit >= 16'd1 && r_digit <= 16'(C_MAX_LEN)) begin
                            n_deflen = r_digit[6:0];
                        end
                    end
                    PH_TEMPO: begin
                        if (r_digit >= 16'(C_MIN_TEMPO) && r_digit <= 16'(C_MAX_TEMPO)) begin
                            n_tempo = r_digit[7:0];
                        end
                    end
                    PH_NUM: begin
                        div_req.len = r_deflen;
                        if (r_digit == 16'd0) begin
                            div_req.start = 1'b1;
                            n_kind  = K_SIL;
                            n_state = ST_DIV;
                        end else if (r_digit <= 16'(C_TONES)) begin
                            div_req.start = 1'b1;
                            n_kind  = K_NOTE;
                            n_freq  = tone_hz(7'(r_digit - 16'd1));
                            n_state = ST_DIV;
                        end
                    end
                    PH_REST: begin
                        div_req.start = 1'b1;
                        n_kind  = K_SIL;
                        n_state = ST_DIV;
                    end
                    PH_NOTE_ACC, PH_NOTE_DIG, PH_NOTE_DOT: begin
                        // c-flat at octave 0 falls below the table
                        if (idx >= 7'd1 && idx <= 7'(C_TONES + 1)) begin
                            div_req.start = 1'b1;
                            div_req.dots  = r_dot;
                            n_kind  = K_NOTE;
                            n_freq  = tone_hz(idx - 7'd1);
                            n_state = ST_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_E1;
                end
            end
            ST_E1: begin
                n_more = 1'b0;
                n_em.last_of_run = 1'b0;
                case (r_kind)
                    K_NOTE: begin
                        n_em.freq_hz = r_freq;
                        n_em.dur_ms  = snd;
                        n_sil        = full - snd;
                        n_more       = (full != snd);
                    end
                    K_RDOT: begin
                        n_em.freq_hz = '0;
                        n_em.dur_ms  = full + (full >> 1);
                    end
                    default: begin
                        n_em.freq_hz = '0;
                        n_em.dur_ms  = full;
                    end
                endcase
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                // the newest beat waits in hold until it is known whether it ends the run
                if (!(r_hold_v && r_out_v)) begin
                    if (r_hold_v) begin
                        n_out   = r_hold;
                        n_out.last_of_run = 1'b0;
                        n_out_v = 1'b1;
                    end
                    n_hold   = r_em;
                    n_hold_v = 1'b1;
                    if (r_more) begin
                        n_em.freq_hz = '0;
                        n_em.dur_ms  = r_sil;
                        n_more       = 1'b0;
                    end else begin
                        n_state = ST_FDONE;
                    end
                end
            end
            ST_FDONE: begin
                clr     = 1'b1;
                n_state = r_ret;
            end
            ST_BEGIN: begin
                case (uc)
                    "O": n_phase = PH_OCT;
                    ">": if (r_oct < 3'd6) n_oct = r_oct + 3'd1;
                    "<": if (r_oct > 3'd0) n_oct = r_oct - 3'd1;
                    "L": n_phase = PH_LEN;
                    "T": n_phase = PH_TEMPO;
                    "V": n_phase = PH_VOL;
                    "M": n_phase = PH_MODE;
                    "N": n_phase = PH_NUM;
                    "P", "R": n_phase = PH_REST;
                    "A": begin n_semi = 5'd10; n_phase = PH_NOTE_ACC; end
                    "B": begin n_semi = 5'd12; n_phase = PH_NOTE_ACC; end
                    "C": begin n_semi = 5'd1;  n_phase = PH_NOTE_ACC; end
                    "D": begin n_semi = 5'd3;  n_phase = PH_NOTE_ACC; end
                    "E": begin n_semi = 5'd5;  n_phase = PH_NOTE_ACC; end
                    "F": begin n_semi = 5'd6;  n_phase = PH_NOTE_ACC; end
                    "G": begin n_semi = 5'd8;  n_phase = PH_NOTE_ACC; end
                    default: ;
                endcase
                n_state = ST_EOS;
            end
            ST_EOS: begin
                if (r_eos) begin
                    n_ret   = ST_RESET;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_END;
                end
            end
            ST_RESET: begin
                n_oct    = 3'd4;
                n_deflen = 7'd4;
                n_tempo  = 8'd120;
                n_artic  = AR_NORMAL;
                clr      = 1'b1;
                n_state  = ST_END;
            end
            ST_END: begin
                if (r_hold_v) begin
                    if (!r_out_v) begin
                        n_out   = r_hold;
                        n_out.last_of_run = 1'b1;
                        n_out_v  = 1'b1;
                        n_hold_v = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (clr) begin
            n_phase = PH_IDLE;
            n_digit = '0;
            n_seen  = 1'b0;
            n_semi  = '0;
            n_dot   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_BEGIN;
            r_oct    <= 3'd4;
            r_deflen <= 7'd4;
            r_tempo  <= 8'd120;
            r_artic  <= AR_NORMAL;
            r_phase  <= PH_IDLE;
            r_digit  <= '0;
            r_seen   <= 1'b0;
            r_semi   <= '0;
            r_dot    <= '0;
            r_more   <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_oct    <= n_oct;
            r_deflen <= n_deflen;
            r_tempo  <= n_tempo;
            r_artic  <= n_artic;
            r_phase  <= n_phase;
            r_digit  <= n_digit;
            r_seen   <= n_seen;
            r_semi   <= n_semi;
            r_dot    <= n_dot;
            r_more   <= n_more;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
        r_ch   <= n_ch;
        r_eos  <= n_eos;
        r_kind <= n_kind;
        r_freq <= n_freq;
        r_sil  <= n_sil;
        r_em   <= n_em;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

### rtl/mmlp_chk.sv
// port-level checker for mml_play_parser, bound to the top level
// depends on mmlp_pkg
module mmlp_chk import mmlp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // an accepted character keeps the parser busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("parser ready right after accepting a character");

    a_freq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.freq_hz <= 12'd2093)
        else $error("frequency beyond table");

    a_dur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.dur_ms <= 14'd15000)
        else $error("duration beyond range");

    // a beat that is not the last of its run is followed while the parser stays busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_run |-> o_in_stall)
        else $error("run left open while parser idle");

endmodule

bind mml_play_parser mmlp_chk u_chk (.*);
